/* hw/rtl/hlc_pkg.sv */
// Package of the history list: codes, controller states and command/status structs.
`default_nettype none

package hlc_pkg;

  localparam int CMD_W   = 3;
  localparam int VAL_W   = 64;
  localparam int IDX_W   = 8;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_LIST   = 3'd1,
    CMD_FWD    = 3'd2,
    CMD_BACK   = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_AT_END    = 3'd2,
    ST_AT_START  = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MOVE_RD,
    S_MOVE_OUT,
    S_LIST_RD,
    S_LIST_OUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_FIN,
    S_DEL_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR1,
    RD_CUR
  } rd_sel_e;

  typedef enum logic [2:0] {
    POS_ZERO,
    POS_COUNT,
    POS_PTR,
    POS_CUR,
    POS_CUR_OR_ZERO
  } pos_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic     in_ready;
    logic     ptr_load_idx;
    logic     ptr_clear;
    logic     ptr_inc;
    rd_sel_e  rd_sel;
    logic     wr_append;
    logic     wr_ptr;
    logic     cur_fwd;
    logic     cur_back;
    logic     del_fix;
    logic     emit;
    status_e  emit_status;
    pos_sel_e emit_pos;
    logic     emit_value;
    logic     emit_last_list;
  } hlc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cmd_taken;
    logic             empty;
    logic             full;
    logic             cur_valid;
    logic             cur_at_end;
    logic             cur_at_start;
    logic             idx_bad;
    logic             ptr_last;
    logic             out_free;
  } hlc_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/hlc_if.sv */
// Request and result channel interfaces of the history list.
`default_nettype none

interface hlc_in_if;
  logic                     valid;
  logic                     ready;
  logic [hlc_pkg::CMD_W-1:0] cmd;
  logic [hlc_pkg::VAL_W-1:0] entry_value;
  logic [hlc_pkg::IDX_W-1:0] index;

  modport source (output valid, cmd, entry_value, index, input ready);
  modport sink   (input valid, cmd, entry_value, index, output ready);
endinterface

interface hlc_out_if;
  logic                      valid;
  logic                      ready;
  logic [hlc_pkg::STAT_W-1:0] status;
  logic [hlc_pkg::VAL_W-1:0]  value;
  logic [hlc_pkg::POS_W-1:0]  position;
  logic                      last;

  modport source (output valid, status, value, position, last, input ready);
  modport sink   (input valid, status, value, position, last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/history_list_with_cursor_top.sv */
// Top level of the history list with cursor: controller and datapath.
//
//  channel | dir | payload                              | handshake
//  --------+-----+--------------------------------------+-------------
//  in_i    | in  | cmd, entry_value, index              | valid/ready
//  out_o   | out | status, value, position, last        | valid/ready
//
// One request is worked at a time; in_i.ready is high only while idle.
// The memory's read is registered, so each compaction write and each listed
// result waits on a read of its own; moves read the entry under the new cursor.
// Reset clears count, cursor, walk pointer and result valid; memory contents
// are undefined until written. A stalled result register holds the walk in place.
`default_nettype none

module history_list_with_cursor_top
  import hlc_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hlc_in_if.sink    in_i,
  hlc_out_if.source out_o
);

  hlc_cmd_t  cmd;
  hlc_stat_t stat;

  hlc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  hlc_datapath #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

`default_nettype wire

/* hw/rtl/hlc_ctrl.sv */
// Controller state machine of the history list.
`default_nettype none

module hlc_ctrl
  import hlc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  hlc_stat_t      stat_i,
  output hlc_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d                = state_q;
    cmd_o                  = '0;
    cmd_o.rd_sel           = RD_PTR;
    cmd_o.emit_status      = ST_OK;
    cmd_o.emit_pos         = POS_ZERO;

    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        // datapath captures the request on valid & ready
        state_d = S_IDLE;
      end

      S_DECODE: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
          case (stat_i.cmd)
            CMD_APPEND: begin
              cmd_o.emit = 1'b1;
              if (stat_i.full) begin
                cmd_o.emit_status = ST_FULL;
              end else begin
                cmd_o.wr_append = 1'b1;
                cmd_o.emit_pos  = POS_COUNT;
              end
            end
            CMD_LIST: begin
              if (stat_i.empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end else begin
                cmd_o.ptr_clear = 1'b1;
                state_d         = S_LIST_RD;
              end
            end
            CMD_FWD: begin
              if (!stat_i.cur_valid) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end else if (stat_i.cur_at_end) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_AT_END;
                cmd_o.emit_pos    = POS_CUR;
              end else begin
                cmd_o.cur_fwd = 1'b1;
                state_d       = S_MOVE_RD;
              end
            end
            CMD_BACK: begin
              if (!stat_i.cur_valid) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end else if (stat_i.cur_at_start) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_AT_START;
                cmd_o.emit_pos    = POS_CUR;
              end else begin
                cmd_o.cur_back = 1'b1;
                state_d        = S_MOVE_RD;
              end
            end
            CMD_DELETE: begin
              if (stat_i.empty) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end else if (stat_i.idx_bad) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_BAD_INDEX;
              end else begin
                cmd_o.ptr_load_idx = 1'b1;
                state_d            = S_DEL_RD;
              end
            end
            default: begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ST_BAD_INDEX;
            end
          endcase
        end
      end

      S_MOVE_RD: begin
        cmd_o.rd_sel = RD_CUR;
        state_d      = S_MOVE_OUT;
      end

      S_MOVE_OUT: begin
        // keep the read on the cursor while the result register is stalled
        cmd_o.rd_sel = RD_CUR;
        if (stat_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_pos   = POS_CUR;
          cmd_o.emit_value = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_LIST_RD: begin
        cmd_o.rd_sel = RD_PTR;
        state_d      = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit           = 1'b1;
          cmd_o.emit_pos       = POS_PTR;
          cmd_o.emit_value     = 1'b1;
          cmd_o.emit_last_list = 1'b1;
          if (stat_i.ptr_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = S_LIST_RD;
          end
        end
      end

      S_DEL_RD: begin
        if (stat_i.ptr_last) begin
          state_d = S_DEL_FIN;
        end else begin
          cmd_o.rd_sel = RD_PTR1;
          state_d      = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        cmd_o.wr_ptr  = 1'b1;
        cmd_o.ptr_inc = 1'b1;
        state_d       = S_DEL_RD;
      end

      S_DEL_FIN: begin
        cmd_o.del_fix = 1'b1;
        state_d       = S_DEL_OUT;
      end

      S_DEL_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_pos = POS_CUR_OR_ZERO;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // leave idle once a request is taken
    if (state_q == S_IDLE && stat_i.cmd_taken) begin
      state_d = S_DECODE;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hlc_datapath.sv */
// Datapath of the history list: entry memory, count, cursor, walk pointer, result register.
`default_nettype none

module hlc_datapath
  import hlc_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hlc_in_if.sink     in_i,
  hlc_out_if.source  out_o,
  input  hlc_cmd_t   cmd_i,
  output hlc_stat_t  stat_o
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > IDX_W) ? CW : IDX_W) + 1;

  // captured request
  logic [CMD_W-1:0]       cmd_q;
  logic [ENTRY_WIDTH-1:0] word_q;
  logic [IDX_W-1:0]       idx_q;

  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] cur_q, cur_d;
  logic          cur_vld_q, cur_vld_d;
  logic [PW-1:0] ptr_q, ptr_d;

  logic                   out_vld_q, out_vld_d;
  logic [STAT_W-1:0]      out_status_q;
  logic [VAL_W-1:0]       out_value_q;
  logic [POS_W-1:0]       out_pos_q;
  logic                   out_last_q;

  logic [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic [ENTRY_WIDTH-1:0] rd_data_q;
  logic [PW-1:0]          rd_addr;
  logic                   wr_en;
  logic [PW-1:0]          wr_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;

  logic            accept;
  logic [PW-1:0]   ptr_nxt;
  logic [CMPW-1:0] ptr_x, cur_x, cnt_x, idx_x, one_x, cnt_new_x;
  logic            ptr_last;
  logic [PW-1:0]   pos_sel;

  assign accept  = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;

  assign ptr_nxt   = PW'(ptr_q + 1'b1);
  assign one_x     = CMPW'(1);
  assign ptr_x     = CMPW'(ptr_q);
  assign cur_x     = CMPW'(cur_q);
  assign cnt_x     = CMPW'(count_q);
  assign idx_x     = CMPW'(idx_q);
  assign cnt_new_x = cnt_x - one_x;
  assign ptr_last  = (ptr_x + one_x) >= cnt_x;

  always_comb begin
    stat_o              = '0;
    stat_o.cmd          = cmd_q;
    stat_o.cmd_taken    = accept;
    stat_o.empty        = (count_q == '0);
    stat_o.full         = (cnt_x == CMPW'(DEPTH));
    stat_o.cur_valid    = cur_vld_q;
    stat_o.cur_at_end   = (cur_x + one_x) >= cnt_x;
    stat_o.cur_at_start = (cur_q == '0);
    stat_o.idx_bad      = idx_x >= cnt_x;
    stat_o.ptr_last     = ptr_last;
    stat_o.out_free     = !out_vld_q || out_o.ready;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.cmd;
      word_q <= in_i.entry_value[ENTRY_WIDTH-1:0];
      idx_q  <= in_i.index;
    end
  end

  // memory: one write port, one registered read port
  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR:  rd_addr = ptr_q;
      RD_PTR1: rd_addr = ptr_nxt;
      RD_CUR:  rd_addr = cur_q;
      default: rd_addr = ptr_q;
    endcase
    wr_en   = cmd_i.wr_append || cmd_i.wr_ptr;
    wr_addr = cmd_i.wr_append ? count_q[PW-1:0] : ptr_q;
    wr_data = cmd_i.wr_append ? word_q : rd_data_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // count, cursor, walk pointer
  always_comb begin
    count_d   = count_q;
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    ptr_d     = ptr_q;

    if (cmd_i.ptr_clear)    ptr_d = '0;
    if (cmd_i.ptr_load_idx) ptr_d = idx_q[PW-1:0];
    if (cmd_i.ptr_inc)      ptr_d = ptr_nxt;

    if (cmd_i.wr_append) begin
      count_d = CW'(count_q + 1'b1);
      if (!cur_vld_q) begin
        cur_vld_d = 1'b1;
        cur_d     = '0;
      end
    end
    if (cmd_i.cur_fwd)  cur_d = PW'(cur_q + 1'b1);
    if (cmd_i.cur_back) cur_d = PW'(cur_q - 1'b1);

    if (cmd_i.del_fix) begin
      count_d = CW'(count_q - 1'b1);
      if (cur_vld_q) begin
        if (cur_x > idx_x) begin
          cur_d = PW'(cur_q - 1'b1);
        end else if (cur_x == idx_x) begin
          if (idx_x < cnt_new_x) begin
            cur_d = cur_q;          // next entry slid under the cursor
          end else if (idx_q != '0) begin
            cur_d = PW'(idx_q - 1'b1);
          end else begin
            cur_vld_d = 1'b0;
            cur_d     = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
      ptr_q     <= '0;
    end else begin
      count_q   <= count_d;
      cur_q     <= cur_d;
      cur_vld_q <= cur_vld_d;
      ptr_q     <= ptr_d;
    end
  end

  // result register
  always_comb begin
    case (cmd_i.emit_pos)
      POS_ZERO:        pos_sel = '0;
      POS_COUNT:       pos_sel = count_q[PW-1:0];
      POS_PTR:         pos_sel = ptr_q;
      POS_CUR:         pos_sel = cur_q;
      POS_CUR_OR_ZERO: pos_sel = cur_vld_q ? cur_q : '0;
      default:         pos_sel = '0;
    endcase
    out_vld_d = out_vld_q;
    if (cmd_i.emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_value_q  <= cmd_i.emit_value ? VAL_W'(rd_data_q) : '0;
      out_pos_q    <= POS_W'(pos_sel);
      out_last_q   <= cmd_i.emit_last_list ? ptr_last : 1'b1;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.status   = out_status_q;
  assign out_o.value    = out_value_q;
  assign out_o.position = out_pos_q;
  assign out_o.last     = out_last_q;

endmodule

`default_nettype wire

/* dv/history_list_checker.sv */
// Scoreboard for the history list: mirrors store and cursor from accepted requests, checks results.
module history_list_checker
  import hlc_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  hlc_in_if    req_i,
  hlc_out_if   res_i,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   entry_count_o
);

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic             last;
  } history_result_t;

  localparam logic [VAL_W-1:0] ENTRY_MASK = {VAL_W{1'b1}} >> (VAL_W - ENTRY_WIDTH);

  logic [VAL_W-1:0] entries [DEPTH];
  int               held       = 0;
  int               cursor_pos = 0;
  bit               cursor_ok  = 1'b0;
  int               mismatches = 0;
  history_result_t  expected_q [$];

  function automatic history_result_t outcome(input status_e st, input logic [VAL_W-1:0] v,
                                              input int pos, input logic fin);
    history_result_t r;
    r.status   = st;
    r.value    = v & ENTRY_MASK;
    r.position = POS_W'(pos);
    r.last     = fin;
    return r;
  endfunction

  // Works out every result of one request and moves the mirrored state on.
  task automatic predict_request(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] word,
                                 input int ix);
    int i;
    case (op)
      CMD_APPEND: begin
        if (held >= DEPTH) begin
          expected_q.push_back(outcome(ST_FULL, '0, 0, 1'b1));
        end else begin
          entries[held] = word & ENTRY_MASK;
          expected_q.push_back(outcome(ST_OK, '0, held, 1'b1));
          held++;
          if (!cursor_ok) begin
            cursor_ok  = 1'b1;
            cursor_pos = 0;
          end
        end
      end
      CMD_LIST: begin
        if (held == 0) begin
          expected_q.push_back(outcome(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (i = 0; i < held; i++)
            expected_q.push_back(outcome(ST_OK, entries[i], i, i == held - 1));
        end
      end
      CMD_FWD: begin
        if (!cursor_ok) begin
          expected_q.push_back(outcome(ST_EMPTY, '0, 0, 1'b1));
        end else if (cursor_pos + 1 < held) begin
          cursor_pos++;
          expected_q.push_back(outcome(ST_OK, entries[cursor_pos], cursor_pos, 1'b1));
        end else begin
          expected_q.push_back(outcome(ST_AT_END, '0, cursor_pos, 1'b1));
        end
      end
      CMD_BACK: begin
        if (!cursor_ok) begin
          expected_q.push_back(outcome(ST_EMPTY, '0, 0, 1'b1));
        end else if (cursor_pos > 0) begin
          cursor_pos--;
          expected_q.push_back(outcome(ST_OK, entries[cursor_pos], cursor_pos, 1'b1));
        end else begin
          expected_q.push_back(outcome(ST_AT_START, '0, cursor_pos, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (held == 0) begin
          expected_q.push_back(outcome(ST_EMPTY, '0, 0, 1'b1));
        end else if (ix >= held) begin
          expected_q.push_back(outcome(ST_BAD_INDEX, '0, 0, 1'b1));
        end else begin
          for (i = ix; i + 1 < held; i++)
            entries[i] = entries[i + 1];
          held--;
          if (cursor_ok && cursor_pos > ix) begin
            cursor_pos--;
          end else if (cursor_ok && cursor_pos == ix && ix >= held) begin
            // newest entry went from under the cursor: step back or drop it
            if (ix > 0) begin
              cursor_pos = ix - 1;
            end else begin
              cursor_ok  = 1'b0;
              cursor_pos = 0;
            end
          end
          expected_q.push_back(outcome(ST_OK, '0, cursor_ok ? cursor_pos : 0, 1'b1));
        end
      end
      default: begin
        expected_q.push_back(outcome(ST_BAD_INDEX, '0, 0, 1'b1));
      end
    endcase
  endtask

  task automatic check_result();
    history_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("unexpected result: status %0d value %h position %0d last %0b",
             res_i.status, res_i.value, res_i.position, res_i.last);
      mismatches++;
    end else begin
      exp_r = expected_q.pop_front();
      if (res_i.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, res_i.status);
        mismatches++;
      end
      if (res_i.value !== exp_r.value) begin
        $error("value: expected %h, actual %h", exp_r.value, res_i.value);
        mismatches++;
      end
      if (res_i.position !== exp_r.position) begin
        $error("position: expected %0d, actual %0d", exp_r.position, res_i.position);
        mismatches++;
      end
      if (res_i.last !== exp_r.last) begin
        $error("last: expected %0b, actual %0b", exp_r.last, res_i.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held       = 0;
      cursor_pos = 0;
      cursor_ok  = 1'b0;
      expected_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (req_i.valid && req_i.ready) predict_request(req_i.cmd, req_i.entry_value, req_i.index);
    end
    pending_o        = expected_q.size();
    entry_count_o    = held;
    mismatch_count_o = mismatches;
  end

endmodule

/* dv/tb_top.sv */
// Testbench top of the history list: clock, reset, request and result traffic, verdict.
module tb_top;
  import hlc_pkg::*;

  localparam int DEPTH         = 16;
  localparam int ENTRY_WIDTH   = 64;
  localparam int RANDOM_REQS   = 300;
  localparam int CALM_REQS     = 40;     // tail of the run with no idling at all
  localparam int PHASE_LEN     = 40;     // requests per fill / drain phase
  localparam int LONG_HOLD     = 60;     // result-side stall, in cycles
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int STALL_LIMIT   = 1000;   // cycles without any handshake

  logic clk;
  logic rst_n;
  bit   idle_en;
  bit   hold_req;
  int   check_failures;
  int   results_due;
  int   entries_held;

  hlc_in_if  req_if ();
  hlc_out_if res_if ();

  history_list_with_cursor_top #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  history_list_checker #(
    .DEPTH       (DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_i            (req_if),
    .res_i            (res_if),
    .mismatch_count_o (check_failures),
    .pending_o        (results_due),
    .entry_count_o    (entries_held)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Entry words: mostly random, with the all-zero, all-one and one-hot corners mixed in.
  function automatic logic [VAL_W-1:0] pick_entry();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One request. Valid is only ever lowered ahead of a gap, so a back-to-back
  // request keeps it high instead of toggling it within one step.
  task automatic send_request(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] word,
                              input logic [IDX_W-1:0] ix);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.cmd         <= op;
    req_if.entry_value <= word;
    req_if.index       <= ix;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender stands back until the checker has seen every result it expects.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    wait (results_due == 0);
    @(negedge clk);
  endtask

  // Result side: short random stalls, plus one long hold-off when asked for.
  initial begin : result_sink
    int gap;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any cycle with a handshake on either channel resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int               n;
    int               roll;
    bit               growing;
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] ix;

    rst_n              = 1'b0;
    idle_en            = 1'b1;
    hold_req           = 1'b0;
    req_if.valid       = 1'b0;
    req_if.cmd         = CMD_APPEND;
    req_if.entry_value = '0;
    req_if.index       = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // ---- Directed requests ----
    // Everything on an empty store with no cursor.
    send_request(CMD_LIST, pick_entry(), 8'($urandom));
    send_request(CMD_FWD, pick_entry(), 8'($urandom));
    send_request(CMD_BACK, pick_entry(), 8'($urandom));
    send_request(CMD_DELETE, pick_entry(), 8'd0);
    // Unknown command codes.
    send_request(3'd5, pick_entry(), 8'($urandom));
    send_request(3'd7, '1, 8'hff);
    // Two entries at the word extremes; the first append creates the cursor.
    send_request(CMD_APPEND, '0, 8'($urandom));
    send_request(CMD_APPEND, '1, 8'($urandom));
    // Cursor bumping both ends and moving in between.
    send_request(CMD_BACK, pick_entry(), 8'($urandom));
    send_request(CMD_FWD, pick_entry(), 8'($urandom));
    send_request(CMD_FWD, pick_entry(), 8'($urandom));
    send_request(CMD_BACK, pick_entry(), 8'($urandom));
    // Bad delete indexes: far off, and exactly one past the newest.
    send_request(CMD_DELETE, pick_entry(), 8'hff);
    send_request(CMD_DELETE, pick_entry(), 8'd2);
    send_request(CMD_LIST, pick_entry(), 8'($urandom));
    // Delete under the cursor with a newer entry sliding in, then the last one.
    send_request(CMD_DELETE, pick_entry(), 8'd0);
    send_request(CMD_DELETE, pick_entry(), 8'd0);
    send_request(CMD_FWD, pick_entry(), 8'($urandom));
    // Cursor beyond the deleted entry follows it down; newest deleted under
    // the cursor sends it back one.
    repeat (3) send_request(CMD_APPEND, pick_entry(), 8'($urandom));
    repeat (2) send_request(CMD_FWD, pick_entry(), 8'($urandom));
    send_request(CMD_DELETE, pick_entry(), 8'd0);
    send_request(CMD_DELETE, pick_entry(), 8'd1);
    drain_results();

    // ---- Back-pressure ----
    // Result side holds off while requests keep coming: the block fills up,
    // overflows into full status and then lists all entries into a stall.
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (DEPTH + 2) send_request(CMD_APPEND, pick_entry(), 8'($urandom));
    send_request(CMD_LIST, pick_entry(), 8'($urandom));
    drain_results();

    // ---- Random requests ----
    // Alternating fill and drain phases so the store swings between empty
    // and full; inside each, cursor moves and lists see varied contents.
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS - CALM_REQS) idle_en = 1'b0;
      if (n == RANDOM_REQS / 2) drain_results();
      growing = ((n / PHASE_LEN) % 2) == 0;
      roll    = $urandom_range(0, 99);
      if (roll < (growing ? 55 : 15))      op = CMD_APPEND;
      else if (roll < (growing ? 63 : 25)) op = CMD_LIST;
      else if (roll < (growing ? 76 : 42)) op = CMD_FWD;
      else if (roll < (growing ? 89 : 59)) op = CMD_BACK;
      else if (roll < 97)                  op = CMD_DELETE;
      else                                 op = 3'($urandom_range(5, 7));
      // mostly hit a live entry; the rest probe out-of-range indexes
      if (op == CMD_DELETE && entries_held > 0 && $urandom_range(0, 9) < 8)
        ix = 8'($urandom_range(0, entries_held - 1));
      else
        ix = 8'($urandom);
      send_request(op, pick_entry(), ix);
    end

    // ---- Wind-down ----
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (check_failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
